// File: sv/hav_pkg.sv
package hav_pkg;

  // CORDIC datapath: inputs are scaled by 2^16, angles are in 2^-16 degree
  localparam int CW     = 36;
  localparam int ZW     = 27;
  localparam int ACC_W  = ZW - 8;
  localparam int ANG_W  = 24;

  localparam logic [15:0]        UNIT_ONE         = 16'd32768;
  localparam logic signed [16:0] US_PER_SIXTEENTH = 17'sd62500;
  localparam logic signed [16:0] INV_GAIN         = 17'sd39797;
  localparam logic signed [ZW-1:0] HALF_TURN      = 27'sd11796480;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GYRO_WEIGHT    = 2'd0;
  localparam cfg_idx_t CFG_VELOCITY_ALPHA = 2'd1;
  localparam cfg_idx_t CFG_ACCEL_Z_ALPHA  = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        step_time;
    logic               flow_valid;
    logic signed [15:0] flow_vel_x;
    logic signed [15:0] flow_vel_y;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] roll_angle;
    logic signed [23:0] pitch_angle;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] smoothed_accel_z;
    logic signed [15:0] smoothed_vel_x;
    logic signed [15:0] smoothed_vel_y;
    logic               flow_healthy;
  } result_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [15:0] value;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] angle;
    logic signed [CW-1:0] mag;
  } cordic_rsp_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58665;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] clamp_unit(input logic [15:0] r);
    return (r > UNIT_ONE) ? UNIT_ONE : r;
  endfunction

endpackage

// File: sv/hav_if.sv
interface hav_sample_if import hav_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hav_result_if import hav_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hav_cfg_if import hav_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/hover_attitude_velocity_estimator_unit.sv
// Channel   Port      Dir  Payload
// sample    sample_i  in   command, accelerometer, gyro, step time, flow
// result    result_o  out  roll, pitch, yaw rate, smoothed accel z and velocity
// config    cfg_i     in   register index and 16-bit value, always ready
//
// A sample is processed by two CORDIC passes and then the blend, which for
// each angle uses two reciprocal-multiply divides by 62500; the first
// sample after reset or restart skips the blend.
// A restart transaction completes in its accept cycle and yields no result.
// Reset clears all filter state and loads the register defaults.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and only a second finished result stalls on a full output.
module hover_attitude_velocity_estimator_unit import hav_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hav_sample_if.sink   sample_i,
  hav_result_if.source result_o,
  hav_cfg_if.sink      cfg_i
);

  localparam int SW = 16 + FRACTION_BITS;  // filter state width
  localparam logic [16:0] DIVISOR = 17'd62500;
  // floor(n / 62500) = (floor(n / 4) * RECIP) >> 43, exact for n < 2^31
  localparam logic [29:0] RECIP = 30'd562949954;
  localparam logic signed [27:0] SAT_MAX = 28'sd8388607;
  localparam logic signed [27:0] SAT_MIN = -28'sd8388608;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ROLL    = 4'd1;
  localparam logic [3:0] S_PITCH   = 4'd2;
  localparam logic [3:0] S_BL_GT   = 4'd3;
  localparam logic [3:0] S_BL_MAG  = 4'd4;
  localparam logic [3:0] S_DV_MUL  = 4'd5;
  localparam logic [3:0] S_DV_REM  = 4'd6;
  localparam logic [3:0] S_BL_Q1   = 4'd7;
  localparam logic [3:0] S_BL_WR   = 4'd8;
  localparam logic [3:0] S_BL_WD   = 4'd9;
  localparam logic [3:0] S_BL_FIN  = 4'd10;
  localparam logic [3:0] S_EMA_MUL = 4'd11;
  localparam logic [3:0] S_EMA_ADD = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0] state_q;

  // configuration
  logic [15:0] gw_q, va_q, aa_q;

  // estimator state
  logic signed [ANG_W-1:0] roll_q, pitch_q;
  logic                    ang_seed_q;
  logic signed [SW-1:0]    az_q, vx_q, vy_q;
  logic                    az_seed_q, vel_seed_q;

  // working registers
  sample_t                 smp_q;
  result_t                 res_q;
  logic                    out_valid_q;
  logic signed [ACC_W-1:0] acc_roll_q, acc_pitch_q;
  logic                    axis_q;
  logic signed [31:0]      gt_q;
  logic [30:0]             dvn_q;
  logic [58:0]             rp_q;
  logic [15:0]             qa_q, ra_q, r1_q;
  logic signed [16:0]      q1_q;
  logic                    neg_q, dsel_q;
  logic signed [42:0]      wd_q;
  logic [1:0]              eidx_q;
  logic signed [SW+17:0]   eprod_q;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  logic in_acc, out_acc, out_free;

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_acc   = sample_i.valid && sample_i.ready;
  assign out_acc  = out_valid_q && result_o.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign cfg_i.ready = 1'b1;

  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;

  // Roll pass runs on (az, ay); the pitch pass runs on (magnitude, -ax).
  assign creq.start = (in_acc && (sample_i.data.command == CMD_SAMPLE)) ||
                      ((state_q == S_ROLL) && crsp.done);
  assign creq.x = (state_q == S_IDLE) ? (CW'(sample_i.data.accel_z) <<< 16) : crsp.mag;
  assign creq.y = (state_q == S_IDLE) ? (CW'(sample_i.data.accel_y) <<< 16)
                                      : -(CW'(smp_q.accel_x) <<< 16);

  hav_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .rsp_o (crsp)
  );

  // blend: new = acc + floor(w * ((old - acc) * 62500 + g * dt) / (2^15 * 62500))
  // With g * dt = 62500 * q1 + r1 (0 <= r1 < 62500) this becomes
  //   acc + ((w * (old - acc + q1) + floor(w * r1 / 62500)) >>> 15)
  // so both divides go through the one reciprocal multiplier.
  logic signed [ANG_W-1:0] old_sel;
  logic signed [ACC_W-1:0] acc_sel;
  logic signed [15:0]      gyro_sel;
  logic signed [24:0]      ang_diff;
  logic [15:0]             w_c;
  logic signed [42:0]      wsum;
  logic signed [27:0]      bsum;
  logic signed [ANG_W-1:0] bsat;

  assign old_sel  = axis_q ? pitch_q : roll_q;
  assign acc_sel  = axis_q ? acc_pitch_q : acc_roll_q;
  assign gyro_sel = axis_q ? smp_q.gyro_y : smp_q.gyro_x;
  assign ang_diff = 25'(old_sel) - 25'(acc_sel);
  assign w_c      = clamp_unit(gw_q);
  assign wsum     = wd_q + 43'($signed({1'b0, qa_q}));
  assign bsum     = 28'(acc_sel) + 28'(wsum >>> 15);

  always_comb begin
    if (bsum > SAT_MAX) begin
      bsat = SAT_MAX[ANG_W-1:0];
    end else if (bsum < SAT_MIN) begin
      bsat = SAT_MIN[ANG_W-1:0];
    end else begin
      bsat = bsum[ANG_W-1:0];
    end
  end

  // low-pass: s += floor(alpha * ((in << F) - s) / 2^15)
  logic signed [15:0]   ema_in;
  logic signed [SW-1:0] ema_s;
  logic [15:0]          ema_alpha;
  logic signed [SW:0]   ema_tgt, ema_diff;
  logic signed [SW-1:0] ema_new, ema_seed;

  always_comb begin
    case (eidx_q)
      2'd0: begin
        ema_in    = smp_q.accel_z;
        ema_s     = az_q;
        ema_alpha = clamp_unit(aa_q);
      end
      2'd1: begin
        ema_in    = smp_q.flow_vel_x;
        ema_s     = vx_q;
        ema_alpha = clamp_unit(va_q);
      end
      default: begin
        ema_in    = smp_q.flow_vel_y;
        ema_s     = vy_q;
        ema_alpha = clamp_unit(va_q);
      end
    endcase
  end

  assign ema_tgt  = (SW+1)'(ema_in) <<< FRACTION_BITS;
  assign ema_diff = ema_tgt - (SW+1)'(ema_s);
  assign ema_seed = ema_tgt[SW-1:0];
  assign ema_new  = ema_s + SW'(eprod_q >>> 15);

  // control and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      gw_q        <= 16'd32113;
      va_q        <= 16'd6554;
      aa_q        <= 16'd4915;
      roll_q      <= '0;
      pitch_q     <= '0;
      ang_seed_q  <= 1'b0;
      az_q        <= '0;
      az_seed_q   <= 1'b0;
      vx_q        <= '0;
      vy_q        <= '0;
      vel_seed_q  <= 1'b0;
      axis_q      <= 1'b0;
      dsel_q      <= 1'b0;
      eidx_q      <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          CFG_GYRO_WEIGHT:    gw_q <= cfg_i.data.value;
          CFG_VELOCITY_ALPHA: va_q <= cfg_i.data.value;
          CFG_ACCEL_Z_ALPHA:  aa_q <= cfg_i.data.value;
          default: ;
        endcase
      end

      // load a finished result, or drop the one taken by the sink
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (sample_i.data.command == CMD_RESTART) begin
              roll_q     <= '0;
              pitch_q    <= '0;
              ang_seed_q <= 1'b0;
              az_q       <= '0;
              az_seed_q  <= 1'b1;
              vx_q       <= '0;
              vy_q       <= '0;
              vel_seed_q <= 1'b1;
            end else begin
              state_q <= S_ROLL;
            end
          end
        end
        S_ROLL: if (crsp.done) state_q <= S_PITCH;
        S_PITCH: begin
          if (crsp.done) begin
            axis_q <= 1'b0;
            eidx_q <= '0;
            if (!ang_seed_q) begin
              // first sample: take the accelerometer angles as they are
              roll_q     <= ANG_W'(acc_roll_q);
              pitch_q    <= ANG_W'(crsp.angle >>> 8);
              ang_seed_q <= 1'b1;
              state_q    <= S_EMA_MUL;
            end else begin
              state_q <= S_BL_GT;
            end
          end
        end
        S_BL_GT:  state_q <= S_BL_MAG;
        S_BL_MAG: begin
          dsel_q  <= 1'b0;
          state_q <= S_DV_MUL;
        end
        S_DV_MUL: state_q <= S_DV_REM;
        S_DV_REM: state_q <= dsel_q ? S_BL_WD : S_BL_Q1;
        S_BL_Q1:  state_q <= S_BL_WR;
        S_BL_WR: begin
          dsel_q  <= 1'b1;
          state_q <= S_DV_MUL;
        end
        S_BL_WD:  state_q <= S_BL_FIN;
        S_BL_FIN: begin
          if (axis_q) begin
            pitch_q <= bsat;
            state_q <= S_EMA_MUL;
          end else begin
            roll_q  <= bsat;
            axis_q  <= 1'b1;
            state_q <= S_BL_GT;
          end
        end
        S_EMA_MUL: state_q <= S_EMA_ADD;
        S_EMA_ADD: begin
          case (eidx_q)
            2'd0: begin
              az_q      <= az_seed_q ? ema_new : ema_seed;
              az_seed_q <= 1'b1;
            end
            2'd1: if (smp_q.flow_valid) vx_q <= vel_seed_q ? ema_new : ema_seed;
            default: begin
              if (smp_q.flow_valid) begin
                vy_q       <= vel_seed_q ? ema_new : ema_seed;
                vel_seed_q <= 1'b1;
              end
            end
          endcase
          if (eidx_q == 2'd2) begin
            state_q <= S_EMIT;
          end else begin
            eidx_q  <= eidx_q + 1'b1;
            state_q <= S_EMA_MUL;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) smp_q <= sample_i.data;
    if ((state_q == S_ROLL) && crsp.done) acc_roll_q <= ACC_W'(crsp.angle >>> 8);
    if ((state_q == S_PITCH) && crsp.done) acc_pitch_q <= ACC_W'(crsp.angle >>> 8);

    case (state_q)
      S_BL_GT:  gt_q <= 32'(gyro_sel) * 32'($signed({1'b0, smp_q.step_time}));
      S_BL_MAG: begin
        neg_q <= gt_q[31];
        dvn_q <= gt_q[31] ? 31'(-gt_q) : gt_q[30:0];
      end
      S_DV_MUL: rp_q <= 59'(dvn_q[30:2]) * 59'(RECIP);
      S_DV_REM: begin
        qa_q <= rp_q[58:43];
        ra_q <= 16'(dvn_q - 31'(rp_q[58:43]) * 31'(DIVISOR));
      end
      S_BL_Q1: begin
        // floor quotient and non-negative remainder of g * dt
        q1_q <= neg_q ? (-17'(qa_q) - 17'(ra_q != '0)) : 17'(qa_q);
        r1_q <= (neg_q && (ra_q != '0)) ? 16'(DIVISOR - 17'(ra_q)) : ra_q;
      end
      S_BL_WR:  dvn_q <= 31'(w_c) * 31'(r1_q);
      S_BL_WD:  wd_q <= 43'($signed({1'b0, w_c})) * 43'(26'(ang_diff) + 26'(q1_q));
      S_EMA_MUL: eprod_q <= $signed({1'b0, ema_alpha}) * ema_diff;
      S_EMIT: begin
        if (out_free) begin
          res_q.roll_angle       <= roll_q;
          res_q.pitch_angle      <= pitch_q;
          res_q.yaw_rate         <= smp_q.gyro_z;
          res_q.smoothed_accel_z <= az_q[SW-1:FRACTION_BITS];
          res_q.smoothed_vel_x   <= vx_q[SW-1:FRACTION_BITS];
          res_q.smoothed_vel_y   <= vy_q[SW-1:FRACTION_BITS];
          res_q.flow_healthy     <= smp_q.flow_valid;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/hav_cordic.sv
module hav_cordic import hav_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  localparam int CNTW = $clog2(STEPS);
  localparam logic [CNTW-1:0] LAST = CNTW'(STEPS - 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_MUL  = 2'd2;
  localparam logic [1:0] C_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNTW-1:0]       cnt_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic                  zero_q;
  logic signed [CW+16:0] prod_q;

  logic signed [CW-1:0]  dx, dy;
  logic signed [ZW-1:0]  step_ang;

  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign step_ang = atan_entry(5'(cnt_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: if (req_i.start) state_d = C_ITER;
      C_ITER: if (cnt_q == LAST) state_d = C_MUL;
      C_MUL:  state_d = C_DONE;
      // a new pass may start while the previous result is shown
      C_DONE: state_d = req_i.start ? C_ITER : C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE, C_DONE: begin
        cnt_q  <= '0;
        zero_q <= (req_i.x == '0) && (req_i.y == '0);
        // left half plane: rotate by half a turn first
        if (req_i.x[CW-1]) begin
          x_q <= -req_i.x;
          y_q <= -req_i.y;
          z_q <= req_i.y[CW-1] ? -HALF_TURN : HALF_TURN;
        end else begin
          x_q <= req_i.x;
          y_q <= req_i.y;
          z_q <= '0;
        end
      end
      C_ITER: begin
        cnt_q <= cnt_q + 1'b1;
        if (!y_q[CW-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + step_ang;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - step_ang;
        end
      end
      C_MUL: prod_q <= x_q * INV_GAIN;
      default: ;
    endcase
  end

  assign rsp_o.done  = (state_q == C_DONE);
  assign rsp_o.angle = zero_q ? '0 : z_q;
  assign rsp_o.mag   = zero_q ? '0 : prod_q[CW+15:16];

endmodule

// File: sv/hav_checker.sv
module hav_checker import hav_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    in_command_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);

  // a sample keeps the block busy
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_command_i == CMD_SAMPLE)) |=> !in_ready_i)
    else $error("ready after sample transaction");

  // restart completes at once
  a_restart_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_command_i == CMD_RESTART)) |=> in_ready_i)
    else $error("not ready after restart transaction");

  // a result appears only at the end of a sample's work
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind hover_attitude_velocity_estimator_unit hav_checker u_hav_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_command_i(sample_i.data.command),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

// File: sim/hav_estimator_checker.sv
`timescale 1ns / 100ps
module hav_estimator_checker import hav_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    smp_fire_i,
  input  sample_t smp_i,
  input  logic    res_fire_i,
  input  result_t res_i,
  input  logic    cfg_fire_i,
  input  cfg_t    cfg_i,
  output int      fail_count_o,
  output int      pending_o
);

  localparam int FB = 8;
  localparam longint W_ONE = 32768;

  longint gyro_weight, vel_alpha, accz_alpha;
  longint roll_q, pitch_q, accz_q, velx_q, vely_q;
  bit     angles_seeded, accz_seeded, vel_seeded;
  result_t expected_results[$];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_w(longint r);
    return (r > W_ONE) ? W_ONE : r;
  endfunction

  // vectoring rotation: angle in 2^-16 degree, magnitude scaled by 1/K
  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
      end
    end
    mag = asr(x * 39797, 16);
    return z;
  endfunction

  function automatic longint blend_angle(longint old, longint g, longint dt,
                                         longint acc, longint w);
    longint num, r;
    num = w * (old * 62500 + g * dt) + (W_ONE - w) * acc * 62500;
    r = floor_div(num, W_ONE * 62500);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  function automatic longint lowpass(longint s, longint in_v, longint a);
    return s + asr(a * ((in_v <<< FB) - s), 15);
  endfunction

  task automatic predict_sample(input sample_t s);
    longint mag, unused, acc_roll, acc_pitch;
    result_t r;
    acc_roll  = asr(vector_angle(longint'(s.accel_z) * 65536,
                                 longint'(s.accel_y) * 65536, mag), 8);
    acc_pitch = asr(vector_angle(mag, -longint'(s.accel_x) * 65536, unused), 8);
    if (!angles_seeded) begin
      roll_q = acc_roll;
      pitch_q = acc_pitch;
      angles_seeded = 1;
    end else begin
      roll_q  = blend_angle(roll_q, s.gyro_x, s.step_time, acc_roll, clamp_w(gyro_weight));
      pitch_q = blend_angle(pitch_q, s.gyro_y, s.step_time, acc_pitch, clamp_w(gyro_weight));
    end
    if (!accz_seeded) begin
      accz_q = longint'(s.accel_z) <<< FB;
      accz_seeded = 1;
    end else accz_q = lowpass(accz_q, s.accel_z, clamp_w(accz_alpha));
    if (s.flow_valid) begin
      if (!vel_seeded) begin
        velx_q = longint'(s.flow_vel_x) <<< FB;
        vely_q = longint'(s.flow_vel_y) <<< FB;
        vel_seeded = 1;
      end else begin
        velx_q = lowpass(velx_q, s.flow_vel_x, clamp_w(vel_alpha));
        vely_q = lowpass(vely_q, s.flow_vel_y, clamp_w(vel_alpha));
      end
    end
    r.roll_angle       = 24'(roll_q);
    r.pitch_angle      = 24'(pitch_q);
    r.yaw_rate         = s.gyro_z;
    r.smoothed_accel_z = 16'(asr(accz_q, FB));
    r.smoothed_vel_x   = 16'(asr(velx_q, FB));
    r.smoothed_vel_y   = 16'(asr(vely_q, FB));
    r.flow_healthy     = s.flow_valid;
    expected_results.push_back(r);
  endtask

  task automatic report(string fname, longint e, longint a);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, e, a);
    fail_count_o++;
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      gyro_weight = 32113; vel_alpha = 6554; accz_alpha = 4915;
      roll_q = 0; pitch_q = 0; accz_q = 0; velx_q = 0; vely_q = 0;
      angles_seeded = 0; accz_seeded = 0; vel_seeded = 0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      // compare first: a result never comes from the sample taken this edge
      if (res_fire_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result, expected none actual %h", $time, res_i);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          if (e.roll_angle != res_i.roll_angle)
            report("roll", e.roll_angle, res_i.roll_angle);
          if (e.pitch_angle != res_i.pitch_angle)
            report("pitch", e.pitch_angle, res_i.pitch_angle);
          if (e.yaw_rate != res_i.yaw_rate) report("yaw", e.yaw_rate, res_i.yaw_rate);
          if (e.smoothed_accel_z != res_i.smoothed_accel_z)
            report("accel_z", e.smoothed_accel_z, res_i.smoothed_accel_z);
          if (e.smoothed_vel_x != res_i.smoothed_vel_x)
            report("vel_x", e.smoothed_vel_x, res_i.smoothed_vel_x);
          if (e.smoothed_vel_y != res_i.smoothed_vel_y)
            report("vel_y", e.smoothed_vel_y, res_i.smoothed_vel_y);
          if (e.flow_healthy != res_i.flow_healthy)
            report("flow_healthy", e.flow_healthy, res_i.flow_healthy);
        end
      end
      if (cfg_fire_i) begin
        case (cfg_i.index)
          CFG_GYRO_WEIGHT:    gyro_weight = cfg_i.value;
          CFG_VELOCITY_ALPHA: vel_alpha   = cfg_i.value;
          CFG_ACCEL_Z_ALPHA:  accz_alpha  = cfg_i.value;
          default: ;
        endcase
      end
      if (smp_fire_i) begin
        if (smp_i.command == CMD_RESTART) begin
          roll_q = 0; pitch_q = 0; angles_seeded = 0;
          accz_q = 0; accz_seeded = 1;
          velx_q = 0; vely_q = 0; vel_seeded = 1;
        end else predict_sample(smp_i);
      end
    end
  end

endmodule

// File: sim/hover_attitude_velocity_estimator_unit_tb.sv
`timescale 1ns / 100ps
module hover_attitude_velocity_estimator_unit_tb;
  import hav_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, idle_cycles;

  hav_sample_if smp_if ();
  hav_result_if res_if ();
  hav_cfg_if    cfg_if ();

  always #5 clk_i = ~clk_i;

  hover_attitude_velocity_estimator_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if.sink),
    .result_o (res_if.source),
    .cfg_i    (cfg_if.sink)
  );

  hav_estimator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_fire_i   (smp_if.valid && smp_if.ready),
    .smp_i        (smp_if.data),
    .res_fire_i   (res_if.valid && res_if.ready),
    .res_i        (res_if.data),
    .cfg_fire_i   (cfg_if.valid && cfg_if.ready),
    .cfg_i        (cfg_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // random stall on the result side
  always @(posedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (smp_if.valid && smp_if.ready || res_if.valid && res_if.ready ||
        cfg_if.valid && cfg_if.ready || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high into the next transaction when there is no gap
  task automatic send_item(input sample_t s);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.data  <= s;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain all results, then cover the trailing restart-free latency
  task automatic drain();
    smp_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rnd16();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'sd0;
    if (r < 5) return 16'($signed($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  function automatic sample_t rnd_sample();
    sample_t s;
    s.command    = ($urandom_range(0, 39) == 0) ? CMD_RESTART : CMD_SAMPLE;
    s.accel_x    = rnd16();
    s.accel_y    = rnd16();
    s.accel_z    = rnd16();
    s.gyro_x     = rnd16();
    s.gyro_y     = rnd16();
    s.gyro_z     = rnd16();
    s.step_time  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5000));
    s.flow_valid = ($urandom_range(0, 3) != 0);
    s.flow_vel_x = rnd16();
    s.flow_vel_y = rnd16();
    return s;
  endfunction

  function automatic logic [15:0] rnd_gain();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd32768;
    if (r == 2) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  initial begin
    sample_t s;
    logic signed [15:0] ext[4];
    ext = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1};
    smp_if.valid = 1'b0;
    smp_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector first, extremes, restart, invalid flow
    s = '0;
    s.flow_valid = 1'b0;
    send_item(s);
    for (int i = 0; i < 16; i++) begin
      s = '0;
      s.accel_x    = ext[i % 4];
      s.accel_y    = ext[(i / 4) % 4];
      s.accel_z    = ext[(i + 1) % 4];
      s.gyro_x     = ext[i % 4];
      s.gyro_y     = ext[(i + 2) % 4];
      s.gyro_z     = ext[(i + 3) % 4];
      s.step_time  = (i % 2) ? 16'hffff : 16'd0;
      s.flow_valid = (i % 3 != 0);
      s.flow_vel_x = ext[(i + 1) % 4];
      s.flow_vel_y = ext[i % 4];
      if (i == 8) s.command = CMD_RESTART;
      send_item(s);
    end
    drain();

    // several register settings, extremes and out-of-range included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_GYRO_WEIGHT, 16'd32768);
          write_reg(CFG_VELOCITY_ALPHA, 16'd0);
          write_reg(CFG_ACCEL_Z_ALPHA, 16'd32768);
        end
        1: begin
          write_reg(CFG_GYRO_WEIGHT, 16'd0);
          write_reg(CFG_VELOCITY_ALPHA, 16'hffff);
          write_reg(CFG_ACCEL_Z_ALPHA, 16'd0);
        end
        2: begin
          write_reg(CFG_GYRO_WEIGHT, 16'hffff);
          write_reg(CFG_VELOCITY_ALPHA, 16'd32768);
          write_reg(CFG_ACCEL_Z_ALPHA, 16'hffff);
          write_reg(cfg_idx_t'(3), 16'h1234);
        end
        default: begin
          write_reg(CFG_GYRO_WEIGHT, rnd_gain());
          write_reg(CFG_VELOCITY_ALPHA, rnd_gain());
          write_reg(CFG_ACCEL_Z_ALPHA, rnd_gain());
        end
      endcase
      for (int n = 0; n < 180; n++) send_item(rnd_sample());
      drain();
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
